>>> rtl/keyed_reader_writer_lock_table_core_defines.svh
// Assertion macros for the keyed reader-writer lock table.
// Used by the port checker; expects clk and rst_n in the calling scope.
`ifndef KEYED_READER_WRITER_LOCK_TABLE_CORE_DEFINES_SVH
`define KEYED_READER_WRITER_LOCK_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define KRWLT_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define KRWLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/krwlt_pkg.sv
// Package for the keyed reader-writer lock table: field widths, codes and types.
// No dependencies; the interfaces, the core and the checker import it.
`timescale 1ns / 1ps
package krwlt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF      = 32;
    localparam int COUNT_BITS_DEF    = 8;

    localparam int ACTION_W    = 2;
    localparam int LOCK_KEY_W  = 32;
    localparam int STATUS_W    = 3;
    localparam int READERS_W   = 8;
    localparam int READERS_MAX = 255;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACQ_RD = 2'd0,
        ACT_ACQ_WR = 2'd1,
        ACT_REL_RD = 2'd2,
        ACT_REL_WR = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_WRITE_REQ = 3'd1,
        ST_WRITER    = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_HELD  = 3'd4,
        ST_SAT       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_DECIDE
    } fsm_t;

endpackage

>>> rtl/krwlt_if.sv
// Valid/ready channel interfaces for lock requests and lock responses.
// Depends on krwlt_pkg for the field widths.
`timescale 1ns / 1ps
interface krwlt_req_if;
    import krwlt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [LOCK_KEY_W-1:0]  lock_key;

    modport source (output valid, output action, output lock_key, input ready);
    modport sink   (input valid, input action, input lock_key, output ready);
endinterface

interface krwlt_rsp_if;
    import krwlt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 granted;
    logic [STATUS_W-1:0]  status;
    logic [READERS_W-1:0] readers_now;

    modport source (output valid, output granted, output status, output readers_now,
                    input ready);
    modport sink   (input valid, input granted, input status, input readers_now,
                    output ready);
endinterface

>>> rtl/krwlt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module krwlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

>>> rtl/keyed_reader_writer_lock_table_core.sv
// Keyed reader-writer lock table with writer preference.
// Depends on krwlt_pkg, krwlt_if and krwlt_ram.
//
// Usage: a request beat on req carries an action (acquire read, acquire write,
// release read, release write) and a lock_key. Each request is one try and
// yields exactly one response beat on rsp with granted, status and the key's
// reader count after the request.
// The entries live in a RAM that is searched one entry per cycle, lowest index
// first; valid bits sit in flip-flops. A request that hits entry i stops its
// scan there; a miss scans the whole table, through the single RAM read port.
// req.ready is high only in the idle state, which follows the cycle in which
// the response is loaded, so a new request is taken only once the last response
// is loaded. A finished response waits in an output register; the next request
// may be accepted and searched meanwhile, and it holds before its update while
// rsp is stalled, so nothing is lost.
// Reset clears all valid bits and control state; the table is empty afterwards
// and ready at once, with no clearing pass.
`timescale 1ns / 1ps
module keyed_reader_writer_lock_table_core #(
    parameter int TABLE_ENTRIES = krwlt_pkg::TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = krwlt_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS    = krwlt_pkg::COUNT_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    krwlt_req_if.sink   req,
    krwlt_rsp_if.source rsp
);
    import krwlt_pkg::*;

    localparam int IW    = $clog2(TABLE_ENTRIES);
    localparam int WORDW = KEY_BITS + COUNT_BITS + 2;

    fsm_t state_reg, state_next;

    logic [IW:0]            scan_reg;
    logic                   cmp_vld_reg;
    logic [IW-1:0]          cmp_idx_reg;
    logic                   free_found_reg;
    logic [IW-1:0]          free_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    action_t                act_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic                   hit_reg;
    logic [IW-1:0]          ent_idx_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic                   req_reg;
    logic                   held_reg;

    logic                   out_valid_reg;
    logic                   granted_reg;
    status_t                status_reg;
    logic [READERS_W-1:0]   readers_reg;

    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [WORDW-1:0]       rd_data;
    logic [KEY_BITS-1:0]    rd_key;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic                   rd_req;
    logic                   rd_held;
    logic                   scan_done;
    logic                   match;
    logic                   last;
    logic                   accept;
    logic                   out_free;

    logic                   wr_en;
    logic [WORDW-1:0]       wr_data;
    logic [COUNT_BITS-1:0]  cur_cnt, new_cnt;
    logic                   cur_req, new_req;
    logic                   cur_held, new_held;
    logic                   have_entry;
    logic                   exists;
    logic                   set_valid;
    logic                   clr_valid;
    logic                   idle_entry;
    logic                   dec_granted;
    status_t                dec_status;
    logic [READERS_W-1:0]   dec_readers;
    logic                   decide_fire;

    assign {rd_key, rd_cnt, rd_req, rd_held} = rd_data;

    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign scan_done = (scan_reg == (IW+1)'(TABLE_ENTRIES));
    assign rd_en     = (state_reg == FSM_SEARCH) && !scan_done;
    assign rd_addr   = scan_reg[IW-1:0];
    assign match     = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_key == key_reg);
    assign last      = cmp_vld_reg && (cmp_idx_reg == IW'(TABLE_ENTRIES - 1));
    assign decide_fire = (state_reg == FSM_DECIDE) && out_free;

    assign req.ready       = (state_reg == FSM_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.granted     = granted_reg;
    assign rsp.status      = status_reg;
    assign rsp.readers_now = readers_reg;

    krwlt_ram #(
        .WIDTH(WORDW),
        .DEPTH(TABLE_ENTRIES)
    ) u_krwlt_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(ent_idx_reg),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        cur_cnt     = hit_reg ? cnt_reg : '0;
        cur_req     = hit_reg && req_reg;
        cur_held    = hit_reg && held_reg;
        have_entry  = hit_reg || free_found_reg;
        new_cnt     = cur_cnt;
        new_req     = cur_req;
        new_held    = cur_held;
        exists      = hit_reg;
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        wr_en       = 1'b0;
        dec_granted = 1'b0;
        dec_status  = ST_OK;
        idle_entry  = 1'b0;
        case (act_reg)
            ACT_ACQ_RD:
            begin
                if (hit_reg && (cur_req || cur_held))
                begin
                    dec_status = ST_WRITER;
                end
                else if (hit_reg && (cur_cnt == '1))
                begin
                    dec_status = ST_SAT;
                end
                else if (!have_entry)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    new_cnt     = cur_cnt + 1'b1;
                    dec_granted = 1'b1;
                    wr_en       = 1'b1;
                    set_valid   = 1'b1;
                    exists      = 1'b1;
                end
            end
            ACT_ACQ_WR:
            begin
                if (hit_reg && (cur_cnt != '0))
                begin
                    new_req    = 1'b1;
                    wr_en      = 1'b1;
                    dec_status = ST_WRITE_REQ;
                end
                else if (hit_reg && cur_held)
                begin
                    dec_status = ST_WRITER;
                end
                else if (!have_entry)
                begin
                    dec_status = ST_FULL;
                end
                else
                begin
                    new_held    = 1'b1;
                    new_req     = 1'b0;
                    dec_granted = 1'b1;
                    wr_en       = 1'b1;
                    set_valid   = 1'b1;
                    exists      = 1'b1;
                end
            end
            ACT_REL_RD:
            begin
                if (!hit_reg || (cur_cnt == '0))
                begin
                    dec_status = ST_NOT_HELD;
                end
                else
                begin
                    new_cnt     = cur_cnt - 1'b1;
                    dec_granted = 1'b1;
                    wr_en       = 1'b1;
                    idle_entry  = (new_cnt == '0) && !new_req && !new_held;
                    clr_valid   = idle_entry;
                    exists      = !idle_entry;
                end
            end
            default:
            begin
                if (!hit_reg || !cur_held)
                begin
                    dec_status = ST_NOT_HELD;
                end
                else
                begin
                    new_held    = 1'b0;
                    dec_granted = 1'b1;
                    wr_en       = 1'b1;
                    idle_entry  = (new_cnt == '0) && !new_req;
                    clr_valid   = idle_entry;
                    exists      = !idle_entry;
                end
            end
        endcase
        wr_en   = wr_en && decide_fire;
        wr_data = {key_reg, new_cnt, new_req, new_held};
        if (!exists)
        begin
            dec_readers = '0;
        end
        else if (32'(new_cnt) > 32'(READERS_MAX))
        begin
            dec_readers = READERS_W'(READERS_MAX);
        end
        else
        begin
            dec_readers = READERS_W'(new_cnt);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (decide_fire && set_valid)
        begin
            valid_next[ent_idx_reg] = 1'b1;
        end
        if (decide_fire && clr_valid)
        begin
            valid_next[ent_idx_reg] = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_SEARCH;
                end
            end
            FSM_SEARCH:
            begin
                if (match || last)
                begin
                    state_next = FSM_DECIDE;
                end
            end
            FSM_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            scan_reg       <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cmp_vld_reg <= rd_en;
            if (accept)
            begin
                scan_reg       <= '0;
                free_found_reg <= 1'b0;
            end
            else if (rd_en)
            begin
                scan_reg <= scan_reg + 1'b1;
                if (!free_found_reg && !valid_reg[rd_addr])
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (decide_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= rd_addr;
        if (accept)
        begin
            act_reg <= action_t'(req.action);
            key_reg <= KEY_BITS'(req.lock_key);
        end
        if (rd_en && !free_found_reg && !valid_reg[rd_addr])
        begin
            free_idx_reg <= rd_addr;
        end
        if ((state_reg == FSM_SEARCH) && match)
        begin
            hit_reg     <= 1'b1;
            ent_idx_reg <= cmp_idx_reg;
            cnt_reg     <= rd_cnt;
            req_reg     <= rd_req;
            held_reg    <= rd_held;
        end
        else if ((state_reg == FSM_SEARCH) && last)
        begin
            hit_reg     <= 1'b0;
            ent_idx_reg <= free_idx_reg;
            cnt_reg     <= '0;
            req_reg     <= 1'b0;
            held_reg    <= 1'b0;
        end
        if (decide_fire)
        begin
            granted_reg <= dec_granted;
            status_reg  <= dec_status;
            readers_reg <= dec_readers;
        end
    end

endmodule

>>> rtl/krwlt_chk.sv
// Port-level checker for the keyed reader-writer lock table, bound to the top level.
// Depends on krwlt_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "keyed_reader_writer_lock_table_core_defines.svh"
module krwlt_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            granted,
    input logic [krwlt_pkg::STATUS_W-1:0]  status,
    input logic [krwlt_pkg::READERS_W-1:0] readers_now
);
    import krwlt_pkg::*;

    // A request beat starts a search, so the request side closes in the next cycle.
    `KRWLT_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready, "ready after a beat")
    // A granted request always reports success.
    `KRWLT_ASSERT(a_grant_is_ok, out_valid && granted, status == ST_OK, "grant with bad status")
    // A full table means the key has no entry, so no readers can be reported.
    `KRWLT_ASSERT(a_full_no_readers, out_valid && (status == ST_FULL),
        !granted && (readers_now == '0), "full table with readers or grant")
    // A stalled response beat must hold its contents.
    `KRWLT_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready,
        out_valid && $stable(granted) && $stable(status) && $stable(readers_now),
        "stalled response changed")

endmodule

bind keyed_reader_writer_lock_table_core krwlt_chk u_krwlt_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .granted    (rsp.granted),
    .status     (rsp.status),
    .readers_now(rsp.readers_now)
);
